### sv/fdmd_pkg.sv
`default_nettype none

package fdmd_pkg;

  // Field and total widths
  localparam int TOTAL_W  = 26;
  localparam int KTOT_W   = 24;
  localparam int PIX_W    = 22;
  localparam int DIM_W    = 11;
  localparam int MEAN_W   = 10;
  localparam int CHAN_W   = 8;
  localparam int PADDR_W  = 4;
  localparam int PDATA_W  = 32;

  typedef logic [TOTAL_W-1:0]  total_t;
  typedef logic [KTOT_W-1:0]   ktot_t;
  typedef logic [PIX_W-1:0]    pix_t;
  typedef logic [DIM_W-1:0]    dim_t;
  typedef logic [MEAN_W-1:0]   mean_t;
  typedef logic [CHAN_W-1:0]   chan_t;
  typedef logic [3*CHAN_W-1:0] rgb_t;

  // Frame result caps
  localparam mean_t MEAN_MAX = 10'd765;
  localparam chan_t AVG_MAX  = 8'd255;

  // Item kinds
  localparam logic [1:0] KIND_PIXEL = 2'd0;
  localparam logic [1:0] KIND_REF   = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  // Register indexes
  localparam logic [1:0] REG_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_SECONDARY = 2'd1;
  localparam logic [1:0] REG_WIDTH     = 2'd2;
  localparam logic [1:0] REG_HEIGHT    = 2'd3;

  // Controller to datapath commands
  typedef struct packed {
    logic clr_en;
    logic accept;
    logic calc;
    logic div_start;
    logic emit;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic clr_done;
    logic frame_end;
    logic is_read;
    logic div_done;
    logic out_free;
  } sts_t;

  function automatic chan_t abs_diff(input chan_t a, input chan_t b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

`default_nettype wire

### sv/fdmd_if.sv
`default_nettype none

interface fdmd_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [15:0] pixel_index;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;

  modport source (output valid, kind, pixel_index, red, green, blue, input ready);
  modport sink (input valid, kind, pixel_index, red, green, blue, output ready);
endinterface

interface fdmd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] motion_value;
  logic       motion_level;
  logic [7:0] average_intensity;
  logic [9:0] mean_motion;

  modport source (output valid, motion_value, motion_level, average_intensity,
                  mean_motion, input ready);
  modport sink (input valid, motion_value, motion_level, average_intensity,
                mean_motion, output ready);
endinterface

`default_nettype wire

### sv/fdmd_div.sv
`default_nettype none

module fdmd_div (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  input  wire fdmd_pkg::total_t num_a,
  input  wire fdmd_pkg::ktot_t  num_b,
  input  wire fdmd_pkg::pix_t   divisor,
  output logic                 done,
  output fdmd_pkg::total_t     quo_a,
  output fdmd_pkg::total_t     quo_b
);

  localparam int NumW = fdmd_pkg::TOTAL_W;
  localparam int RemW = fdmd_pkg::PIX_W;
  localparam int CntW = $clog2(NumW);
  localparam logic [CntW-1:0] LastStep = CntW'(NumW - 1);

  logic                 busy_r;
  logic                 done_r;
  logic [CntW-1:0]      cnt_r;
  fdmd_pkg::total_t     qa_r;
  fdmd_pkg::total_t     qb_r;
  logic [RemW-1:0]      ra_r;
  logic [RemW-1:0]      rb_r;
  fdmd_pkg::pix_t       dvs_r;

  logic [RemW:0]        sh_a;
  logic [RemW:0]        sh_b;
  logic [RemW:0]        sub_a;
  logic [RemW:0]        sub_b;
  logic                 ge_a;
  logic                 ge_b;
  logic [RemW-1:0]      ra_nxt;
  logic [RemW-1:0]      rb_nxt;

  // One restoring step per cycle on both dividends
  always_comb begin
    sh_a   = {ra_r, qa_r[NumW-1]};
    sh_b   = {rb_r, qb_r[NumW-1]};
    sub_a  = sh_a - {1'b0, dvs_r};
    sub_b  = sh_b - {1'b0, dvs_r};
    ge_a   = (sh_a >= {1'b0, dvs_r});
    ge_b   = (sh_b >= {1'b0, dvs_r});
    ra_nxt = ge_a ? sub_a[RemW-1:0] : sh_a[RemW-1:0];
    rb_nxt = ge_b ? sub_b[RemW-1:0] : sh_b[RemW-1:0];
  end

  // Sequence control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == LastStep) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Load operands, then shift quotient bits in
  always_ff @(posedge clk) begin
    if (start) begin
      qa_r  <= num_a;
      qb_r  <= fdmd_pkg::total_t'(num_b);
      ra_r  <= '0;
      rb_r  <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      qa_r <= {qa_r[NumW-2:0], ge_a};
      qb_r <= {qb_r[NumW-2:0], ge_b};
      ra_r <= ra_nxt;
      rb_r <= rb_nxt;
    end
  end

  assign done  = done_r;
  assign quo_a = qa_r;
  assign quo_b = qb_r;

endmodule

`default_nettype wire

### sv/fdmd_ctrl.sv
`default_nettype none

module fdmd_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire fdmd_pkg::sts_t sts,
  output fdmd_pkg::cmd_t      cmd
);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_CALC  = 5'b00100,
    S_DIV   = 5'b01000,
    S_EMIT  = 5'b10000
  } state_t;

  state_t st_r;
  state_t st_nxt;

  // Next state and commands
  always_comb begin
    st_nxt   = st_r;
    cmd      = '0;
    in_ready = 1'b0;
    unique case (st_r)
      S_CLEAR: begin
        cmd.clr_en = 1'b1;
        if (sts.clr_done) st_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid) st_nxt = S_CALC;
      end
      S_CALC: begin
        cmd.calc = 1'b1;
        if (sts.frame_end) begin
          cmd.div_start = 1'b1;
          st_nxt        = S_DIV;
        end else if (sts.is_read) begin
          st_nxt = S_EMIT;
        end else begin
          st_nxt = S_IDLE;
        end
      end
      S_DIV: begin
        if (sts.div_done) st_nxt = S_EMIT;
      end
      S_EMIT: begin
        cmd.emit = 1'b1;
        if (sts.out_free) st_nxt = S_IDLE;
      end
      default: begin
        st_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_CLEAR;
    end else begin
      st_r <= st_nxt;
    end
  end

endmodule

`default_nettype wire

### sv/fdmd_dp.sv
`default_nettype none

module fdmd_dp #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire fdmd_pkg::cmd_t  cmd,
  output fdmd_pkg::sts_t       sts,
  input  wire logic [1:0]      in_kind,
  input  wire logic [15:0]     in_pixel_index,
  input  wire fdmd_pkg::chan_t in_red,
  input  wire fdmd_pkg::chan_t in_green,
  input  wire fdmd_pkg::chan_t in_blue,
  input  wire logic [9:0]      cfg_threshold,
  input  wire logic            cfg_secondary,
  input  wire logic [8:0]      cfg_width,
  input  wire logic [8:0]      cfg_height,
  input  wire logic            out_ready,
  output logic                 out_valid,
  output fdmd_pkg::chan_t      out_motion_value,
  output logic                 out_motion_level,
  output fdmd_pkg::chan_t      out_average_intensity,
  output fdmd_pkg::mean_t      out_mean_motion
);

  localparam int Prod  = MAX_WIDTH * MAX_HEIGHT;
  localparam int Depth = (Prod > 65536) ? 65536 : Prod;
  localparam int AW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam logic [AW-1:0]  LastAddr = AW'(Depth - 1);
  localparam fdmd_pkg::dim_t MaxW     = fdmd_pkg::dim_t'(MAX_WIDTH);
  localparam fdmd_pkg::dim_t MaxH     = fdmd_pkg::dim_t'(MAX_HEIGHT);

  // Frame stores
  fdmd_pkg::rgb_t  ref_mem [Depth];
  fdmd_pkg::chan_t mot_mem [Depth];

  logic [1:0]       kind_r;
  logic [15:0]      idx_r;
  fdmd_pkg::rgb_t   pix_r;
  fdmd_pkg::rgb_t   ref_q_r;
  fdmd_pkg::chan_t  mot_q_r;
  fdmd_pkg::total_t diff_tot_r;
  fdmd_pkg::ktot_t  kept_tot_r;
  fdmd_pkg::mean_t  mean_r;
  fdmd_pkg::chan_t  avg_r;
  logic             level_r;
  fdmd_pkg::chan_t  res_val_r;
  logic [AW-1:0]    clr_cnt_r;
  logic             out_valid_r;
  fdmd_pkg::chan_t  out_value_r;
  logic             out_level_r;
  fdmd_pkg::chan_t  out_avg_r;
  fdmd_pkg::mean_t  out_mean_r;

  fdmd_pkg::dim_t   cw;
  fdmd_pkg::dim_t   ch;
  fdmd_pkg::pix_t   pixels;
  logic             idx_ok;
  logic             is_last;
  logic [9:0]       dsum;
  fdmd_pkg::chan_t  kept;
  logic [fdmd_pkg::TOTAL_W:0] diff_sum;
  logic [fdmd_pkg::KTOT_W:0]  kept_sum;
  fdmd_pkg::total_t diff_nxt;
  fdmd_pkg::ktot_t  kept_nxt;
  logic             pix_item;
  logic             ref_we;
  logic [AW-1:0]    ref_wa;
  fdmd_pkg::rgb_t   ref_wd;
  logic             mot_we;
  logic [11:0]      mean3;
  fdmd_pkg::chan_t  supp_val;
  logic             out_free;
  logic             out_load;
  logic             div_done;
  fdmd_pkg::total_t quo_a;
  fdmd_pkg::total_t quo_b;
  fdmd_pkg::mean_t  mean_nxt;
  fdmd_pkg::chan_t  avg_nxt;

  // Frame size in use
  always_comb begin
    if (cfg_width == 9'd0) begin
      cw = fdmd_pkg::dim_t'(1);
    end else if (fdmd_pkg::dim_t'(cfg_width) > MaxW) begin
      cw = MaxW;
    end else begin
      cw = fdmd_pkg::dim_t'(cfg_width);
    end
    if (cfg_height == 9'd0) begin
      ch = fdmd_pkg::dim_t'(1);
    end else if (fdmd_pkg::dim_t'(cfg_height) > MaxH) begin
      ch = MaxH;
    end else begin
      ch = fdmd_pkg::dim_t'(cfg_height);
    end
    pixels  = fdmd_pkg::pix_t'(cw) * fdmd_pkg::pix_t'(ch);
    idx_ok  = fdmd_pkg::pix_t'(idx_r) < pixels;
    is_last = fdmd_pkg::pix_t'(idx_r) == (pixels - fdmd_pkg::pix_t'(1));
  end

  // Channel differences, threshold and saturating totals
  always_comb begin
    dsum = 10'(fdmd_pkg::abs_diff(pix_r[23:16], ref_q_r[23:16]))
         + 10'(fdmd_pkg::abs_diff(pix_r[15:8],  ref_q_r[15:8]))
         + 10'(fdmd_pkg::abs_diff(pix_r[7:0],   ref_q_r[7:0]));
    if (dsum > cfg_threshold) begin
      kept = (dsum > 10'd255) ? fdmd_pkg::AVG_MAX : dsum[7:0];
    end else begin
      kept = '0;
    end
    diff_sum = {1'b0, diff_tot_r} + (fdmd_pkg::TOTAL_W + 1)'(dsum);
    kept_sum = {1'b0, kept_tot_r} + (fdmd_pkg::KTOT_W + 1)'(kept);
    diff_nxt = diff_sum[fdmd_pkg::TOTAL_W] ? '1 : diff_sum[fdmd_pkg::TOTAL_W-1:0];
    kept_nxt = kept_sum[fdmd_pkg::KTOT_W] ? '1 : kept_sum[fdmd_pkg::KTOT_W-1:0];
    pix_item = cmd.calc && (kind_r == fdmd_pkg::KIND_PIXEL) && idx_ok;
  end

  // Reference store write port: clearing pass, then items
  always_comb begin
    ref_we = 1'b0;
    ref_wa = idx_r[AW-1:0];
    ref_wd = pix_r;
    if (cmd.clr_en) begin
      ref_we = 1'b1;
      ref_wa = clr_cnt_r;
      ref_wd = '0;
    end else if (cmd.calc && idx_ok &&
                 (((kind_r == fdmd_pkg::KIND_PIXEL) && !cfg_secondary) ||
                  ((kind_r == fdmd_pkg::KIND_REF) && cfg_secondary))) begin
      ref_we = 1'b1;
    end
    mot_we = pix_item;
  end

  always_ff @(posedge clk) begin
    if (ref_we) ref_mem[ref_wa] <= ref_wd;
    if (cmd.accept) ref_q_r <= ref_mem[in_pixel_index[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (mot_we) mot_mem[idx_r[AW-1:0]] <= kept;
    if (cmd.accept) mot_q_r <= mot_mem[in_pixel_index[AW-1:0]];
  end

  // Advance the clearing pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_en) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  // Capture the item
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      kind_r <= in_kind;
      idx_r  <= in_pixel_index;
      pix_r  <= {in_red, in_green, in_blue};
    end
  end

  // Accumulate totals; clear them when the frame ends
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      diff_tot_r <= '0;
      kept_tot_r <= '0;
    end else if (pix_item) begin
      if (is_last) begin
        diff_tot_r <= '0;
        kept_tot_r <= '0;
      end else begin
        diff_tot_r <= diff_nxt;
        kept_tot_r <= kept_nxt;
      end
    end
  end

  // Hold the value to report
  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      if (kind_r == fdmd_pkg::KIND_PIXEL) begin
        res_val_r <= kept;
      end else begin
        res_val_r <= idx_ok ? mot_q_r : '0;
      end
    end
  end

  fdmd_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cmd.div_start),
    .num_a   (diff_nxt),
    .num_b   (kept_nxt),
    .divisor (pixels),
    .done    (div_done),
    .quo_a   (quo_a),
    .quo_b   (quo_b)
  );

  // Frame results, capped
  always_comb begin
    mean_nxt = (quo_a > fdmd_pkg::total_t'(fdmd_pkg::MEAN_MAX)) ?
               fdmd_pkg::MEAN_MAX : quo_a[fdmd_pkg::MEAN_W-1:0];
    avg_nxt  = (quo_b > fdmd_pkg::total_t'(fdmd_pkg::AVG_MAX)) ?
               fdmd_pkg::AVG_MAX : quo_b[fdmd_pkg::CHAN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mean_r  <= '0;
      avg_r   <= '0;
      level_r <= 1'b0;
    end else if (div_done) begin
      mean_r  <= mean_nxt;
      avg_r   <= avg_nxt;
      level_r <= (mean_nxt == fdmd_pkg::MEAN_MAX);
    end
  end

  // Suppress values below three times the frame mean
  always_comb begin
    mean3    = {2'b00, mean_r} + {1'b0, mean_r, 1'b0};
    supp_val = (12'(res_val_r) < mean3) ? '0 : res_val_r;
    out_free = !out_valid_r || out_ready;
    out_load = cmd.emit && out_free;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_value_r <= supp_val;
      out_level_r <= level_r;
      out_avg_r   <= avg_r;
      out_mean_r  <= mean_r;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_motion_value      = out_value_r;
  assign out_motion_level      = out_level_r;
  assign out_average_intensity = out_avg_r;
  assign out_mean_motion       = out_mean_r;

  always_comb begin
    sts.clr_done  = (clr_cnt_r == LastAddr);
    sts.frame_end = (kind_r == fdmd_pkg::KIND_PIXEL) && idx_ok && is_last;
    sts.is_read   = (kind_r == fdmd_pkg::KIND_READ);
    sts.div_done  = div_done;
    sts.out_free  = out_free;
  end

  a_totals_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |=> (diff_tot_r == '0) && (kept_tot_r == '0))
    else $error("frame totals not cleared at frame end");

  a_level_matches_mean: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |=> (mean_r <= fdmd_pkg::MEAN_MAX) &&
                 (level_r == (mean_r == fdmd_pkg::MEAN_MAX)))
    else $error("frame mean or motion level out of step");

  a_no_item_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clr_en |-> !(cmd.accept || cmd.calc || cmd.emit))
    else $error("item handled during reference clearing pass");

endmodule

`default_nettype wire

### sv/frame_difference_motion_detector.sv
// Path: an item passes the accept, compute and load states before its result enters the
// output register; the last pixel of a frame also waits on a 26-step shared divider.
// Items: the controller takes a new item only in its idle state, once the last is through;
// the single-ported frame stores are read at accept and written in the cycle after.
// Reset (rst_n low, synchronous) clears control and totals, then a clearing pass zeros
// the reference store, one entry per cycle (MAX_WIDTH*MAX_HEIGHT entries, at most 65536).
`default_nettype none

module frame_difference_motion_detector #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  fdmd_in_if.sink                               in_ch,
  fdmd_out_if.source                            out_ch,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [fdmd_pkg::PADDR_W-1:0]     paddr,
  input  wire logic [fdmd_pkg::PDATA_W-1:0]     pwdata,
  output logic      [fdmd_pkg::PDATA_W-1:0]     prdata,
  output logic                                  pready
);

  logic [9:0] thr_r;
  logic       sec_r;
  logic [8:0] width_r;
  logic [8:0] height_r;
  logic       cfg_wr;
  logic [1:0] reg_sel;

  fdmd_pkg::cmd_t  cmd;
  fdmd_pkg::sts_t  sts;
  logic            in_ready;
  logic            out_valid;
  fdmd_pkg::chan_t out_motion_value;
  logic            out_motion_level;
  fdmd_pkg::chan_t out_average_intensity;
  fdmd_pkg::mean_t out_mean_motion;

  // Register write on the access phase
  assign pready  = 1'b1;
  assign reg_sel = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r    <= '0;
      sec_r    <= 1'b0;
      width_r  <= 9'd256;
      height_r <= 9'd256;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        fdmd_pkg::REG_THRESHOLD: thr_r    <= pwdata[9:0];
        fdmd_pkg::REG_SECONDARY: sec_r    <= pwdata[0];
        fdmd_pkg::REG_WIDTH:     width_r  <= pwdata[8:0];
        fdmd_pkg::REG_HEIGHT:    height_r <= pwdata[8:0];
        default:                 thr_r    <= thr_r;
      endcase
    end
  end

  // Register readback
  always_comb begin
    unique case (reg_sel)
      fdmd_pkg::REG_THRESHOLD: prdata = fdmd_pkg::PDATA_W'(thr_r);
      fdmd_pkg::REG_SECONDARY: prdata = fdmd_pkg::PDATA_W'(sec_r);
      fdmd_pkg::REG_WIDTH:     prdata = fdmd_pkg::PDATA_W'(width_r);
      fdmd_pkg::REG_HEIGHT:    prdata = fdmd_pkg::PDATA_W'(height_r);
      default:                 prdata = '0;
    endcase
  end

  fdmd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  fdmd_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .sts                   (sts),
    .in_kind               (in_ch.kind),
    .in_pixel_index        (in_ch.pixel_index),
    .in_red                (in_ch.red),
    .in_green              (in_ch.green),
    .in_blue               (in_ch.blue),
    .cfg_threshold         (thr_r),
    .cfg_secondary         (sec_r),
    .cfg_width             (width_r),
    .cfg_height            (height_r),
    .out_ready             (out_ch.ready),
    .out_valid             (out_valid),
    .out_motion_value      (out_motion_value),
    .out_motion_level      (out_motion_level),
    .out_average_intensity (out_average_intensity),
    .out_mean_motion       (out_mean_motion)
  );

  assign in_ch.ready              = in_ready;
  assign out_ch.valid             = out_valid;
  assign out_ch.motion_value      = out_motion_value;
  assign out_ch.motion_level      = out_motion_level;
  assign out_ch.average_intensity = out_average_intensity;
  assign out_ch.mean_motion       = out_mean_motion;

endmodule

`default_nettype wire
